>>> src/wavhp_pkg.sv
// ----------------------------------------------------------------------------
// WAV header parser package
// Shared types, tag values, status codes and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package wavhp_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h52494646;
   localparam logic [31:0] TAG_WAVE = 32'h57415645;
   localparam logic [31:0] TAG_FMT  = 32'h666D7420;
   localparam logic [31:0] TAG_DATA = 32'h64617461;

   localparam logic [2:0] STS_BUSY       = 3'd0;
   localparam logic [2:0] STS_COMPLETE   = 3'd1;
   localparam logic [2:0] STS_BAD_RIFF   = 3'd2;
   localparam logic [2:0] STS_BAD_WAVE   = 3'd3;
   localparam logic [2:0] STS_BAD_FMT    = 3'd4;
   localparam logic [2:0] STS_TRUNCATED  = 3'd5;
   localparam logic [2:0] STS_ZERO_ALIGN = 3'd6;
   localparam logic [2:0] STS_IGNORED    = 3'd7;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_SCAN,
      PH_LENGTH,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      CTL_READY,
      CTL_MUL,
      CTL_DIV,
      CTL_LOAD
   } ctl_state_type;

   typedef struct packed {
      logic accept;
      logic load_plain;
      logic div_init;
      logic div_step;
      logic load_derived;
   } dp_cmd_type;

   typedef struct packed {
      logic derive;
      logic div_last;
   } dp_status_type;

endpackage

>>> src/wavhp_ctrl.sv
// ----------------------------------------------------------------------------
// WAV header parser controller
// Handshake control and sequencing of the multiply and divide at completion.
// ----------------------------------------------------------------------------
module wavhp_ctrl import wavhp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type sts,
   output dp_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   assign req_ready = (state_ff == CTL_READY) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_READY: begin
            if (accept && sts.derive) state_in = CTL_MUL;
         end
         CTL_MUL: begin
            state_in = CTL_DIV;
         end
         CTL_DIV: begin
            if (sts.div_last) state_in = CTL_LOAD;
         end
         CTL_LOAD: begin
            state_in = CTL_READY;
         end
         default: begin
            state_in = CTL_READY;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         CTL_READY: begin
            cmd.accept     = accept;
            cmd.load_plain = accept && !sts.derive;
         end
         CTL_MUL: begin
            cmd.div_init = 1'b1;
         end
         CTL_DIV: begin
            cmd.div_step = 1'b1;
         end
         CTL_LOAD: begin
            cmd.load_derived = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_plain || cmd.load_derived) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_READY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_derive_enters_mul: assert property (@(posedge clock) disable iff (reset)
      (accept && sts.derive) |=> (state_ff == CTL_MUL))
      else $error("derive transfer did not start the multiply");

   a_busy_output_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != CTL_READY) |-> !rsp_valid_ff)
      else $error("result pending while derived values are computed");

   a_load_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTL_LOAD) |-> ($past(state_ff) == CTL_DIV))
      else $error("derived load without a finished divide");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step || cmd.div_init || cmd.load_derived) |-> !cmd.accept)
      else $error("transfer accepted during derive sequence");

endmodule

>>> src/wavhp_datapath.sv
// ----------------------------------------------------------------------------
// WAV header parser datapath
// Byte parser, header field registers, multipliers, serial divider, result.
// ----------------------------------------------------------------------------
module wavhp_datapath import wavhp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type sts,
   input  logic [7:0]    req_data_byte,
   input  logic          req_start_of_file,
   input  logic          req_end_of_stream,
   output logic [2:0]    rsp_parse_status,
   output logic [31:0]   rsp_file_size,
   output logic [31:0]   rsp_format_length,
   output logic [15:0]   rsp_format_code,
   output logic [15:0]   rsp_channels,
   output logic [31:0]   rsp_sample_rate,
   output logic [15:0]   rsp_bits_per_channel,
   output logic [31:0]   rsp_data_length,
   output logic [31:0]   rsp_bits_per_sample,
   output logic [15:0]   rsp_bytes_per_sample,
   output logic [31:0]   rsp_bytes_per_second,
   output logic [31:0]   rsp_sample_count
);

   function automatic logic [31:0] put32(logic [31:0] f, logic [7:0] b, logic [1:0] lane);
      logic [31:0] ext;
      ext = {24'd0, b};
      return f | (ext << {lane, 3'b000});
   endfunction

   function automatic logic [15:0] put16(logic [15:0] f, logic [7:0] b, logic lane);
      logic [15:0] ext;
      ext = {8'd0, b};
      return f | (ext << {lane, 3'b000});
   endfunction

   phase_type   phase_ff, phase_in, phase_base;
   logic [5:0]  pos_ff, pos_in, pos_base;
   logic [31:0] window_ff, window_in, window_base, window_upd;
   logic [31:0] size_ff, size_in, size_base;
   logic [31:0] fmtlen_ff, fmtlen_in, fmtlen_base;
   logic [15:0] format_ff, format_in, format_base;
   logic [15:0] chan_ff, chan_in, chan_base;
   logic [31:0] rate_ff, rate_in, rate_base;
   logic [15:0] align_ff, align_in, align_base;
   logic [15:0] depth_ff, depth_in, depth_base;
   logic [31:0] length_ff, length_in, length_base;
   logic [2:0]  status_in;
   logic [2:0]  dstatus_ff;
   logic        derive;
   logic        active;

   logic [31:0] bc_ff;
   logic [34:0] rbc_ff;
   logic [63:0] rbc_full;
   logic [31:0] div_q_ff;
   logic [15:0] div_r_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [16:0] div_shift, div_diff;
   logic        div_ge;

   always_comb begin
      phase_base  = req_start_of_file ? PH_HEADER : phase_ff;
      pos_base    = req_start_of_file ? 6'd0  : pos_ff;
      window_base = req_start_of_file ? 32'd0 : window_ff;
      size_base   = req_start_of_file ? 32'd0 : size_ff;
      fmtlen_base = req_start_of_file ? 32'd0 : fmtlen_ff;
      format_base = req_start_of_file ? 16'd0 : format_ff;
      chan_base   = req_start_of_file ? 16'd0 : chan_ff;
      rate_base   = req_start_of_file ? 32'd0 : rate_ff;
      align_base  = req_start_of_file ? 16'd0 : align_ff;
      depth_base  = req_start_of_file ? 16'd0 : depth_ff;
      length_base = req_start_of_file ? 32'd0 : length_ff;
      window_upd  = {window_base[23:0], req_data_byte};

      phase_in  = phase_base;
      pos_in    = pos_base;
      window_in = window_base;
      size_in   = size_base;
      fmtlen_in = fmtlen_base;
      format_in = format_base;
      chan_in   = chan_base;
      rate_in   = rate_base;
      align_in  = align_base;
      depth_in  = depth_base;
      length_in = length_base;
      status_in = STS_BUSY;
      derive    = 1'b0;
      active    = 1'b1;

      case (phase_base)
         PH_HEADER: begin
            window_in = window_upd;
            if (pos_base == 6'd3 && window_upd != TAG_RIFF) status_in = STS_BAD_RIFF;
            else if (pos_base >= 6'd4 && pos_base <= 6'd7)
               size_in = put32(size_base, req_data_byte, pos_base[1:0]);
            else if (pos_base == 6'd11 && window_upd != TAG_WAVE) status_in = STS_BAD_WAVE;
            else if (pos_base == 6'd15 && window_upd != TAG_FMT) status_in = STS_BAD_FMT;
            else if (pos_base >= 6'd16 && pos_base <= 6'd19)
               fmtlen_in = put32(fmtlen_base, req_data_byte, pos_base[1:0]);
            else if (pos_base >= 6'd20 && pos_base <= 6'd21)
               format_in = put16(format_base, req_data_byte, pos_base[0]);
            else if (pos_base >= 6'd22 && pos_base <= 6'd23)
               chan_in = put16(chan_base, req_data_byte, pos_base[0]);
            else if (pos_base >= 6'd24 && pos_base <= 6'd27)
               rate_in = put32(rate_base, req_data_byte, pos_base[1:0]);
            else if (pos_base >= 6'd32 && pos_base <= 6'd33)
               align_in = put16(align_base, req_data_byte, pos_base[0]);
            else if (pos_base >= 6'd34 && pos_base <= 6'd35)
               depth_in = put16(depth_base, req_data_byte, pos_base[0]);

            if (status_in == STS_BUSY) begin
               if (pos_base >= 6'd39) begin
                  pos_in   = 6'd0;
                  phase_in = (window_upd == TAG_DATA) ? PH_LENGTH : PH_SCAN;
               end else begin
                  pos_in = pos_base + 6'd1;
               end
            end
         end
         PH_SCAN: begin
            window_in = window_upd;
            if (window_upd == TAG_DATA) begin
               phase_in = PH_LENGTH;
               pos_in   = 6'd0;
            end
         end
         PH_LENGTH: begin
            window_in = window_upd;
            length_in = put32(length_base, req_data_byte, pos_base[1:0]);
            if (pos_base[1:0] == 2'd3) begin
               derive    = 1'b1;
               status_in = (align_base == 16'd0) ? STS_ZERO_ALIGN : STS_COMPLETE;
            end else begin
               pos_in = pos_base + 6'd1;
            end
         end
         default: begin
            active    = 1'b0;
            status_in = STS_IGNORED;
         end
      endcase

      if (active) begin
         if (status_in == STS_BUSY && req_end_of_stream) status_in = STS_TRUNCATED;
         if (status_in != STS_BUSY) phase_in = PH_DONE;
      end
   end

   assign div_shift = {div_r_ff, div_q_ff[31]};
   assign div_diff  = div_shift - {1'b0, align_ff};
   assign div_ge    = div_shift >= {1'b0, align_ff};
   assign rbc_full  = {32'd0, rate_ff} * {32'd0, bc_ff};

   assign sts.derive   = derive;
   assign sts.div_last = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pos_ff    <= 6'd0;
         window_ff <= 32'd0;
         size_ff   <= 32'd0;
         fmtlen_ff <= 32'd0;
         format_ff <= 16'd0;
         chan_ff   <= 16'd0;
         rate_ff   <= 32'd0;
         align_ff  <= 16'd0;
         depth_ff  <= 16'd0;
         length_ff <= 32'd0;
      end else if (cmd.accept) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         window_ff <= window_in;
         size_ff   <= size_in;
         fmtlen_ff <= fmtlen_in;
         format_ff <= format_in;
         chan_ff   <= chan_in;
         rate_ff   <= rate_in;
         align_ff  <= align_in;
         depth_ff  <= depth_in;
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) dstatus_ff <= status_in;
      if (cmd.div_init) begin
         bc_ff      <= {16'd0, depth_ff} * {16'd0, chan_ff};
         div_q_ff   <= length_ff;
         div_r_ff   <= 16'd0;
         div_cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rbc_ff     <= rbc_full[34:0];
         div_q_ff   <= {div_q_ff[30:0], div_ge};
         div_r_ff   <= div_ge ? div_diff[15:0] : div_shift[15:0];
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_plain) begin
         rsp_parse_status     <= status_in;
         rsp_file_size        <= size_in;
         rsp_format_length    <= fmtlen_in;
         rsp_format_code      <= format_in;
         rsp_channels         <= chan_in;
         rsp_sample_rate      <= rate_in;
         rsp_bits_per_channel <= depth_in;
         rsp_data_length      <= length_in;
         rsp_bits_per_sample  <= 32'd0;
         rsp_bytes_per_sample <= 16'd0;
         rsp_bytes_per_second <= 32'd0;
         rsp_sample_count     <= 32'd0;
      end else if (cmd.load_derived) begin
         rsp_parse_status     <= dstatus_ff;
         rsp_file_size        <= size_ff;
         rsp_format_length    <= fmtlen_ff;
         rsp_format_code      <= format_ff;
         rsp_channels         <= chan_ff;
         rsp_sample_rate      <= rate_ff;
         rsp_bits_per_channel <= depth_ff;
         rsp_data_length      <= length_ff;
         rsp_bits_per_sample  <= bc_ff;
         rsp_bytes_per_sample <= bc_ff[18:3];
         rsp_bytes_per_second <= rbc_ff[34:3];
         rsp_sample_count     <= (align_ff == 16'd0) ? 32'd0 : div_q_ff;
      end
   end

endmodule

>>> src/wav_header_parser.sv
// ----------------------------------------------------------------------------
// WAV header parser
// Parses a RIFF/WAVE header from a byte stream and reports its fields.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the file one byte per transfer on the req_ channel, with
//   req_start_of_file on byte 0 and req_end_of_stream on the last byte
//   the stream holds. Every accepted byte yields exactly one result on
//   the rsp_ channel: the parse status and the header fields held so far.
//   A result is registered and appears the cycle after its byte is taken,
//   so header bytes flow at one per cycle while results are taken.
//   The fourth data length byte completes the parse; its result carries
//   the derived fields and appears after the channel-by-depth multiply,
//   the bit-serial sample count divider (which also forms the byte rate
//   product) and the load of the result. No byte is taken while they run.
//   When the receiver stalls, the result holds and req_ready drops until
//   the result is taken or taken in the same cycle.
//   Reset clears all header fields and waits for a start-of-file byte;
//   bytes before it report status ignored.
// ----------------------------------------------------------------------------
module wav_header_parser import wavhp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_file,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_parse_status,
   output logic [31:0] rsp_file_size,
   output logic [31:0] rsp_format_length,
   output logic [15:0] rsp_format_code,
   output logic [15:0] rsp_channels,
   output logic [31:0] rsp_sample_rate,
   output logic [15:0] rsp_bits_per_channel,
   output logic [31:0] rsp_data_length,
   output logic [31:0] rsp_bits_per_sample,
   output logic [15:0] rsp_bytes_per_sample,
   output logic [31:0] rsp_bytes_per_second,
   output logic [31:0] rsp_sample_count
);

   dp_cmd_type    cmd;
   dp_status_type sts;

   wavhp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   wavhp_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_data_byte        (req_data_byte),
      .req_start_of_file    (req_start_of_file),
      .req_end_of_stream    (req_end_of_stream),
      .rsp_parse_status     (rsp_parse_status),
      .rsp_file_size        (rsp_file_size),
      .rsp_format_length    (rsp_format_length),
      .rsp_format_code      (rsp_format_code),
      .rsp_channels         (rsp_channels),
      .rsp_sample_rate      (rsp_sample_rate),
      .rsp_bits_per_channel (rsp_bits_per_channel),
      .rsp_data_length      (rsp_data_length),
      .rsp_bits_per_sample  (rsp_bits_per_sample),
      .rsp_bytes_per_sample (rsp_bytes_per_sample),
      .rsp_bytes_per_second (rsp_bytes_per_second),
      .rsp_sample_count     (rsp_sample_count)
   );

endmodule
